// ===== rtl/mcsa_pkg.sv =====
// Package for the microphone channel select and average block.
// Holds the shared types, register indexes and datapath constants.
// Used by mcsa_addsub, mcsa_datapath, mcsa_ctrl and mic_channel_select_average.
package mcsa_pkg;

    // Limits of the supported configuration.
    localparam logic [3:0] MAX_RAW_CHANNELS = 4'd8;
    localparam logic [3:0] MAX_MICS         = 4'd4;
    localparam logic [3:0] MIC_SLOTS        = 4'd4;

    // Frame sum width: enough for every add a frame can collect.
    localparam int SUM_W  = 21;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    localparam int SAMPLE_W = 16;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RAW_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] CFG_MIC_COUNT         = 3'd1;
    localparam logic [2:0] CFG_MIC_INDEX_A       = 3'd2;
    localparam logic [2:0] CFG_MIC_INDEX_B       = 3'd3;
    localparam logic [2:0] CFG_MIC_INDEX_C       = 3'd4;
    localparam logic [2:0] CFG_MIC_INDEX_D       = 3'd5;

    typedef struct packed {
        logic [3:0]      raw_channel_count;
        logic [2:0]      mic_count;
        logic [3:0][2:0] mic_index;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_ABS,
        S_DIV,
        S_NEG,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_ACCUM,
        DP_ABS,
        DP_DIV,
        DP_NEG,
        DP_CLEAR
    } dp_op_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        dp_op_t     op;
        logic       load;
        logic       match;
        logic [2:0] divisor;
    } dp_ctrl_t;

    // What the pending result carries.
    typedef struct packed {
        logic use_avg;
        logic status;
        logic done;
    } result_kind_t;

endpackage

// ===== rtl/mic_channel_select_average.sv =====
// Top level of the microphone channel select and average block.
// Holds the configuration registers and the output register.
// Depends on mcsa_pkg, mcsa_ctrl and mcsa_datapath.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: sample_in; tlast: end_of_buffer
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: mixed_sample; tuser: status_code;
//                                                   tlast: buffer_done
// cfg       in         cfg_we                       cfg_index, cfg_data
//
// An item inside a frame passes through the shared adder once per selected
// microphone. The item that closes a frame then goes through the absolute value,
// the 21-step serial divider and the negation. With an unsupported configuration
// an item is not accumulated, and one that ends the buffer gives a status result.
// Reset clears the frame position and the frame sum. The output register holds
// one result; a stall on m_axis stops the block only when a second result is ready.
module mic_channel_select_average (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] mixed_sample
    output logic        m_axis_tuser,   // [0] status_code
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    mcsa_pkg::cfg_t         cfg_reg;
    mcsa_pkg::dp_ctrl_t     dp_ctrl;
    mcsa_pkg::result_kind_t kind;

    logic        emit_valid;
    logic        emit_take;
    logic [15:0] average;

    logic        out_valid_reg;
    logic [15:0] out_sample_reg;
    logic        out_status_reg;
    logic        out_done_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_channel_count <= 4'd2;
            cfg_reg.mic_count         <= 3'd1;
            cfg_reg.mic_index         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mcsa_pkg::CFG_RAW_CHANNEL_COUNT: cfg_reg.raw_channel_count <= cfg_data;
                mcsa_pkg::CFG_MIC_COUNT:         cfg_reg.mic_count         <= cfg_data[2:0];
                mcsa_pkg::CFG_MIC_INDEX_A:       cfg_reg.mic_index[0]      <= cfg_data[2:0];
                mcsa_pkg::CFG_MIC_INDEX_B:       cfg_reg.mic_index[1]      <= cfg_data[2:0];
                mcsa_pkg::CFG_MIC_INDEX_C:       cfg_reg.mic_index[2]      <= cfg_data[2:0];
                mcsa_pkg::CFG_MIC_INDEX_D:       cfg_reg.mic_index[3]      <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    mcsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_last    (s_axis_tlast),
        .emit_take  (emit_take),
        .in_ready   (s_axis_tready),
        .emit_valid (emit_valid),
        .kind       (kind),
        .dp_ctrl    (dp_ctrl)
    );

    mcsa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dp_ctrl),
        .sample_in (s_axis_tdata),
        .average   (average)
    );

    // A result moves into the output register when that register is empty or m_axis takes its result.
    assign emit_take = emit_valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (emit_take)
        begin
            out_sample_reg <= kind.use_avg ? average : 16'd0;
            out_status_reg <= kind.status;
            out_done_reg   <= kind.done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_done_reg;

endmodule

// ===== rtl/mcsa_addsub.sv =====
// Shared adder/subtractor of the microphone average block.
// Used for accumulation, absolute value, division steps and negation.
// Depends on mcsa_pkg.
module mcsa_addsub (
    input  logic [mcsa_pkg::SUM_W-1:0] a,
    input  logic [mcsa_pkg::SUM_W-1:0] b,
    input  logic                       sub,
    output logic [mcsa_pkg::SUM_W-1:0] y
);

    // Two's complement add, or subtract by inverting b and carrying in.
    assign y = a + (sub ? ~b : b) + {{(mcsa_pkg::SUM_W-1){1'b0}}, sub};

endmodule

// ===== rtl/mcsa_datapath.sv =====
// Datapath of the microphone average block: frame sum, divider registers.
// Every arithmetic step goes through the one mcsa_addsub instance.
// Depends on mcsa_pkg and mcsa_addsub.
module mcsa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcsa_pkg::dp_ctrl_t            ctrl,
    input  logic [mcsa_pkg::SAMPLE_W-1:0] sample_in,
    output logic [mcsa_pkg::SAMPLE_W-1:0] average
);

    localparam int W = mcsa_pkg::SUM_W;

    logic [W-1:0]                  sum_reg;
    logic [W-1:0]                  mag_reg;
    logic [2:0]                    rem_reg;
    logic                          neg_reg;
    logic [mcsa_pkg::SAMPLE_W-1:0] sample_reg;

    logic [W-1:0] op_a;
    logic [W-1:0] op_b;
    logic         op_sub;
    logic [W-1:0] op_y;
    logic [3:0]   trial;

    // Partial remainder with the next dividend bit shifted in.
    assign trial = {rem_reg, mag_reg[W-1]};

    // Operand selection for the shared unit.
    always_comb
    begin
        op_a   = sum_reg;
        op_b   = '0;
        op_sub = 1'b0;
        case (ctrl.op)
            mcsa_pkg::DP_ACCUM:
            begin
                op_a = sum_reg;
                op_b = {{(W-mcsa_pkg::SAMPLE_W){sample_reg[mcsa_pkg::SAMPLE_W-1]}}, sample_reg};
            end
            mcsa_pkg::DP_ABS:
            begin
                op_a   = '0;
                op_b   = sum_reg;
                op_sub = 1'b1;
            end
            mcsa_pkg::DP_DIV:
            begin
                op_a   = {{(W-4){1'b0}}, trial};
                op_b   = {{(W-3){1'b0}}, ctrl.divisor};
                op_sub = 1'b1;
            end
            mcsa_pkg::DP_NEG:
            begin
                op_a   = '0;
                op_b   = mag_reg;
                op_sub = 1'b1;
            end
            default:
            begin
                op_a   = sum_reg;
                op_b   = '0;
                op_sub = 1'b0;
            end
        endcase
    end

    mcsa_addsub u_addsub (
        .a   (op_a),
        .b   (op_b),
        .sub (op_sub),
        .y   (op_y)
    );

    // Frame sum, cleared by reset and after each result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.op == mcsa_pkg::DP_ACCUM && ctrl.match)
        begin
            sum_reg <= op_y;
        end
        else if (ctrl.op == mcsa_pkg::DP_CLEAR)
        begin
            sum_reg <= '0;
        end
    end

    // Sample capture and restoring division registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sample_reg <= sample_in;
        end
        case (ctrl.op)
            mcsa_pkg::DP_ABS:
            begin
                neg_reg <= sum_reg[W-1];
                mag_reg <= sum_reg[W-1] ? op_y : sum_reg;
                rem_reg <= '0;
            end
            mcsa_pkg::DP_DIV:
            begin
                if (!op_y[W-1])
                begin
                    rem_reg <= op_y[2:0];
                    mag_reg <= {mag_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[2:0];
                    mag_reg <= {mag_reg[W-2:0], 1'b0};
                end
            end
            mcsa_pkg::DP_NEG:
            begin
                if (neg_reg)
                begin
                    mag_reg <= op_y;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign average = mag_reg[mcsa_pkg::SAMPLE_W-1:0];

endmodule

// ===== rtl/mcsa_ctrl.sv =====
// Sequencer of the microphone average block: frame position, microphone
// scan, divide step count and result kind. Depends on mcsa_pkg.
module mcsa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mcsa_pkg::cfg_t         cfg,
    input  logic                   in_valid,
    input  logic                   in_last,
    input  logic                   emit_take,
    output logic                   in_ready,
    output logic                   emit_valid,
    output mcsa_pkg::result_kind_t kind,
    output mcsa_pkg::dp_ctrl_t     dp_ctrl
);

    mcsa_pkg::state_t state_reg;
    mcsa_pkg::state_t state_next;

    logic [2:0]                      pos_reg;
    logic [1:0]                      mic_sel_reg;
    logic [mcsa_pkg::STEP_W-1:0]     step_reg;
    logic                            eob_reg;
    mcsa_pkg::result_kind_t          kind_reg;

    logic accept;
    logic unsupported;
    logic last_mic;
    logic frame_end;

    // Configuration check: counts in range and every used index below the
    // channel count.
    always_comb
    begin
        unsupported = (cfg.raw_channel_count == 4'd0)
                   || (cfg.raw_channel_count > mcsa_pkg::MAX_RAW_CHANNELS)
                   || (cfg.mic_count == 3'd0)
                   || ({1'b0, cfg.mic_count} > mcsa_pkg::MAX_MICS)
                   || ({1'b0, cfg.mic_count} > mcsa_pkg::MIC_SLOTS);
        for (int i = 0; i < 4; i++)
        begin
            if ((3'(i) < cfg.mic_count)
                && ({1'b0, cfg.mic_index[i]} >= cfg.raw_channel_count))
            begin
                unsupported = 1'b1;
            end
        end
    end

    // The input is ready exactly in the idle state.
    assign accept    = in_valid && (state_reg == mcsa_pkg::S_IDLE);
    assign last_mic  = (({1'b0, mic_sel_reg} + 3'd1) == cfg.mic_count);
    assign frame_end = (({1'b0, pos_reg} + 4'd1) >= cfg.raw_channel_count);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcsa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (unsupported)
                    begin
                        state_next = in_last ? mcsa_pkg::S_EMIT : mcsa_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = mcsa_pkg::S_ACCUM;
                    end
                end
            end
            mcsa_pkg::S_ACCUM:
            begin
                if (last_mic)
                begin
                    if (frame_end)
                    begin
                        state_next = mcsa_pkg::S_ABS;
                    end
                    else
                    begin
                        state_next = eob_reg ? mcsa_pkg::S_EMIT : mcsa_pkg::S_IDLE;
                    end
                end
            end
            mcsa_pkg::S_ABS:
            begin
                state_next = mcsa_pkg::S_DIV;
            end
            mcsa_pkg::S_DIV:
            begin
                if (step_reg == mcsa_pkg::LAST_STEP)
                begin
                    state_next = mcsa_pkg::S_NEG;
                end
            end
            mcsa_pkg::S_NEG:
            begin
                state_next = mcsa_pkg::S_EMIT;
            end
            mcsa_pkg::S_EMIT:
            begin
                if (emit_take)
                begin
                    state_next = mcsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mcsa_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb
    begin
        in_ready           = 1'b0;
        emit_valid         = 1'b0;
        dp_ctrl.op         = mcsa_pkg::DP_HOLD;
        dp_ctrl.load       = accept;
        dp_ctrl.match      = (cfg.mic_index[mic_sel_reg] == pos_reg);
        dp_ctrl.divisor    = cfg.mic_count;
        unique case (state_reg)
            mcsa_pkg::S_IDLE:  in_ready   = 1'b1;
            mcsa_pkg::S_ACCUM: dp_ctrl.op = mcsa_pkg::DP_ACCUM;
            mcsa_pkg::S_ABS:   dp_ctrl.op = mcsa_pkg::DP_ABS;
            mcsa_pkg::S_DIV:   dp_ctrl.op = mcsa_pkg::DP_DIV;
            mcsa_pkg::S_NEG:   dp_ctrl.op = mcsa_pkg::DP_NEG;
            mcsa_pkg::S_EMIT:
            begin
                emit_valid = 1'b1;
                dp_ctrl.op = mcsa_pkg::DP_CLEAR;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign kind = kind_reg;

    // State, position, counters and result kind.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mcsa_pkg::S_IDLE;
            pos_reg     <= '0;
            mic_sel_reg <= '0;
            step_reg    <= '0;
            eob_reg     <= 1'b0;
            kind_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                mcsa_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        eob_reg     <= in_last;
                        mic_sel_reg <= '0;
                        if (unsupported)
                        begin
                            if (in_last)
                            begin
                                pos_reg  <= '0;
                                kind_reg <= '{use_avg: 1'b0, status: 1'b1, done: 1'b1};
                            end
                            else
                            begin
                                pos_reg <= pos_reg + 3'd1;
                            end
                        end
                    end
                end
                mcsa_pkg::S_ACCUM:
                begin
                    mic_sel_reg <= mic_sel_reg + 2'd1;
                    if (last_mic)
                    begin
                        if (frame_end)
                        begin
                            pos_reg  <= '0;
                            kind_reg <= '{use_avg: 1'b1, status: 1'b0, done: eob_reg};
                        end
                        else if (eob_reg)
                        begin
                            pos_reg  <= '0;
                            kind_reg <= '{use_avg: 1'b0, status: 1'b0, done: 1'b1};
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 3'd1;
                        end
                    end
                end
                mcsa_pkg::S_ABS:
                begin
                    step_reg <= '0;
                end
                mcsa_pkg::S_DIV:
                begin
                    step_reg <= step_reg + mcsa_pkg::STEP_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // The divider always starts from step zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcsa_pkg::S_ABS) |=> (state_reg == mcsa_pkg::S_DIV && step_reg == '0))
        else $error("divider did not start at step zero");

    // The divider runs exactly one step per quotient bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcsa_pkg::S_DIV && step_reg == mcsa_pkg::LAST_STEP)
        |=> (state_reg == mcsa_pkg::S_NEG))
        else $error("divider ran past its last step");

    // Every delivered result leaves the block idle at the start of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcsa_pkg::S_EMIT && emit_take)
        |=> (state_reg == mcsa_pkg::S_IDLE && pos_reg == 3'd0))
        else $error("frame position not restarted after a result");

endmodule
